/* hdl/lfpd_pkg.sv */
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared types and constants of the length-framed packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lfpd_pkg;

    // Field widths.
    localparam int BYTE_W   = 8;
    localparam int CMD_W    = 16;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 12;
    localparam int SUM_W    = 16;
    localparam int PHASE_W  = 3;

    // Packed result data width, rounded up to whole bytes.
    localparam int RES_BITS = BYTE_W + CMD_W + STATUS_W + LEN_W;
    localparam int TDATA_W  = ((RES_BITS + 7) / 8) * 8;

    // Receive buffer size; a frame larger than this minus the header is refused.
    localparam int BUFFER_BYTES = 4096;
    localparam int FRAME_OVERHEAD = 6;

    // Smallest legal length: command word plus checksum.
    localparam logic [LEN_W-1:0] MIN_LENGTH = LEN_W'(4);

    // Reset value of the max_length register.
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = LEN_W'(4090);

    // Head bytes.
    localparam logic [BYTE_W-1:0] HEAD_FIRST  = 8'hFF;
    localparam logic [BYTE_W-1:0] HEAD_SECOND = 8'hFE;

    // Parser phases.
    localparam logic [PHASE_W-1:0] PH_HUNT = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LEN  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CMD  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DATA = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CHKL = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CHKH = 3'd5;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // Frame status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 2'd2;

    // One result item.
    typedef struct packed {
        logic                kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic [CMD_W-1:0]    command_code;
        logic [STATUS_W-1:0] frame_status;
        logic [LEN_W-1:0]    payload_count;
        logic                last;
    } result_t;

endpackage

`default_nettype wire

/* hdl/length_framed_packet_deframer.sv */
// ----------------------------------------------------------------------------
// length_framed_packet_deframer
// Byte-wise frame parser: head hunt, length, command, payload pass-through
// with a 16-bit additive checksum, and one report at the end of each frame.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while it is not stalled, and the whole
// parser step is one pass of logic from the state registers into the result
// register, and a new byte is taken whenever the result register is empty or
// being read in the same cycle. Each payload byte comes out as an item with
// tuser 0; each frame ends with one item with tuser 1 and tlast high that
// carries the command, the payload count and the status (ok, checksum
// mismatch, or bad length). A bad length is reported right after the fourth
// length byte, and the head hunt resumes with the next byte.
`default_nettype none

module length_framed_packet_deframer
    import lfpd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    // Configuration: max_length.
    input  wire logic               cfg_wr_en,
    input  wire logic [LEN_W-1:0]   cfg_wr_data,

    // Input byte stream.
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [BYTE_W-1:0]  s_tdata,    // [7:0] data_byte

    // Result stream.
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // [7:0] payload_byte, [23:8] command_code, [25:24] frame_status,
    // [37:26] payload_count, [39:38] zero
    output logic [TDATA_W-1:0]      m_tdata,
    output logic                    m_tuser,    // [0] kind
    output logic                    m_tlast     // last
);

    // State registers.
    logic [PHASE_W-1:0] phase_reg,   phase_next;
    logic               saw_ff_reg,  saw_ff_next;
    logic [LEN_W-1:0]   len_reg,     len_next;
    logic               len_big_reg, len_big_next;
    logic [LEN_W-1:0]   cnt_reg,     cnt_next;
    logic [CMD_W-1:0]   cmd_reg,     cmd_next;
    logic [SUM_W-1:0]   sum_reg,     sum_next;
    logic [BYTE_W-1:0]  chk_lo_reg,  chk_lo_next;
    logic [LEN_W-1:0]   max_len_reg;

    // Result register.
    logic               out_valid_reg;
    result_t            out_reg;

    // Step outputs.
    logic               in_fire;
    logic               res_valid;
    result_t            res;
    logic               len_bad;
    logic [LEN_W-1:0]   data_len;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign data_len = len_reg - MIN_LENGTH;

    // Length check on the fully assembled length field.
    always_comb begin
        len_bad = len_big_next || (len_next < MIN_LENGTH) || (len_next > max_len_reg) ||
                  (32'(len_next) > 32'(BUFFER_BYTES - FRAME_OVERHEAD));
    end

    // One parser step per accepted item.
    always_comb begin
        phase_next   = phase_reg;
        saw_ff_next  = saw_ff_reg;
        len_next     = len_reg;
        len_big_next = len_big_reg;
        cnt_next     = cnt_reg;
        cmd_next     = cmd_reg;
        sum_next     = sum_reg;
        chk_lo_next  = chk_lo_reg;
        res_valid    = 1'b0;
        res          = '0;

        if (in_fire) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (saw_ff_reg && s_tdata == HEAD_SECOND) begin
                        phase_next   = PH_LEN;
                        saw_ff_next  = 1'b0;
                        cnt_next     = '0;
                        len_next     = '0;
                        len_big_next = 1'b0;
                    end else begin
                        saw_ff_next = (s_tdata == HEAD_FIRST);
                    end
                end

                PH_LEN: begin
                    // Little-endian assembly; bits above the 12-bit range only mark it too big.
                    case (cnt_reg[1:0])
                        2'd0: begin
                            len_next[7:0] = s_tdata;
                        end
                        2'd1: begin
                            len_next[LEN_W-1:8] = s_tdata[LEN_W-9:0];
                            len_big_next = len_big_reg || (s_tdata[7:LEN_W-8] != '0);
                        end
                        default: begin
                            len_big_next = len_big_reg || (s_tdata != '0);
                        end
                    endcase
                    cnt_next = cnt_reg + LEN_W'(1);
                    if (cnt_reg[1:0] == 2'd3) begin
                        if (len_bad) begin
                            phase_next          = PH_HUNT;
                            saw_ff_next         = 1'b0;
                            cnt_next            = '0;
                            res_valid           = 1'b1;
                            res.kind            = KIND_END;
                            res.frame_status    = ST_BAD_LEN;
                            res.last            = 1'b1;
                        end else begin
                            phase_next = PH_CMD;
                            cnt_next   = '0;
                            cmd_next   = '0;
                        end
                    end
                end

                PH_CMD: begin
                    if (cnt_reg == '0) begin
                        cmd_next = {8'h00, s_tdata};
                        cnt_next = LEN_W'(1);
                    end else begin
                        cmd_next   = {s_tdata, cmd_reg[7:0]};
                        cnt_next   = '0;
                        sum_next   = '0;
                        phase_next = (len_reg == MIN_LENGTH) ? PH_CHKL : PH_DATA;
                    end
                end

                PH_DATA: begin
                    sum_next = sum_reg + SUM_W'(s_tdata);
                    cnt_next = cnt_reg + LEN_W'(1);
                    if (cnt_next >= data_len) begin
                        phase_next = PH_CHKL;
                    end
                    res_valid        = 1'b1;
                    res.kind         = KIND_PAYLOAD;
                    res.payload_byte = s_tdata;
                    res.command_code = cmd_reg;
                end

                PH_CHKL: begin
                    chk_lo_next = s_tdata;
                    phase_next  = PH_CHKH;
                end

                PH_CHKH: begin
                    phase_next        = PH_HUNT;
                    saw_ff_next       = 1'b0;
                    cnt_next          = '0;
                    res_valid         = 1'b1;
                    res.kind          = KIND_END;
                    res.command_code  = cmd_reg;
                    res.frame_status  = ({s_tdata, chk_lo_reg} == sum_reg) ? ST_OK : ST_CHECKSUM;
                    res.payload_count = data_len;
                    res.last          = 1'b1;
                end

                default: begin
                    phase_next  = PH_HUNT;
                    saw_ff_next = 1'b0;
                    cnt_next    = '0;
                end
            endcase
        end
    end

    // State and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            saw_ff_reg  <= 1'b0;
            len_reg     <= '0;
            len_big_reg <= 1'b0;
            cnt_reg     <= '0;
            cmd_reg     <= '0;
            sum_reg     <= '0;
            chk_lo_reg  <= '0;
            max_len_reg <= MAX_LENGTH_RST;
        end else begin
            phase_reg   <= phase_next;
            saw_ff_reg  <= saw_ff_next;
            len_reg     <= len_next;
            len_big_reg <= len_big_next;
            cnt_reg     <= cnt_next;
            cmd_reg     <= cmd_next;
            sum_reg     <= sum_next;
            chk_lo_reg  <= chk_lo_next;
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
        end
    end

    // Result register: loads whenever it is free or being read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && res_valid) begin
            out_reg <= res;
        end
    end

    // Output packing.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'({out_reg.payload_count, out_reg.frame_status,
                                out_reg.command_code, out_reg.payload_byte});
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

    // Checks.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_PAYLOAD) |->
            (m_tdata[25:24] == ST_OK && m_tdata[37:26] == '0 && !m_tlast))
        else $error("payload item carries frame end fields");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LEN) |-> (cnt_reg < LEN_W'(4)))
        else $error("length byte counter out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && phase_reg == PH_HUNT && saw_ff_reg && s_tdata == HEAD_SECOND)
            |=> (phase_reg == PH_LEN))
        else $error("head not detected");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (cnt_reg < data_len))
        else $error("payload counter past frame length");

endmodule

`default_nettype wire

/* tb/tb_length_framed_packet_deframer.sv */
// ----------------------------------------------------------------------------
// tb_length_framed_packet_deframer
// Self-checking bench for the length-framed packet deframer. Byte streams with
// well-formed frames, bad lengths, checksum errors and line noise are driven
// in bursts. A behavioral parser in the bench predicts every payload item and
// every frame end report, and each result is checked field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_length_framed_packet_deframer;
    import lfpd_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 6;
    localparam int MAX_REPORTS  = 50;
    localparam longint TIMEOUT_NS = 64'd8_000_000;

    typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_SPARSE} rx_pace_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0]   cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata     = '0;
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;
    logic               m_tlast;

    // Parser state of the bench's own model.
    logic [PHASE_W-1:0] model_phase      = PH_HUNT;
    logic               model_saw_ff     = 1'b0;
    logic [31:0]        model_length     = '0;
    logic [12:0]        model_count      = '0;
    logic [CMD_W-1:0]   model_command    = '0;
    logic [SUM_W-1:0]   model_sum        = '0;
    logic [BYTE_W-1:0]  model_check_low  = '0;
    logic [LEN_W-1:0]   model_max_length = MAX_LENGTH_RST;

    result_t     pending_results[$];
    int unsigned bytes_sent   = 0;
    int unsigned burst_left   = 0;
    int unsigned mismatches   = 0;
    rx_pace_t    rx_pace      = RX_FREE;
    int unsigned rx_pace_left = 0;

    length_framed_packet_deframer u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // Free-running clock.
    always #CLK_HALF aclk = ~aclk;

    // Run timeout.
    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    // Advance the model by one accepted byte and queue the result it causes.
    function automatic void predict_frame_byte(input logic [BYTE_W-1:0] b);
        case (model_phase)
            PH_HUNT: begin
                if (model_saw_ff && b == HEAD_SECOND) begin
                    model_phase  = PH_LEN;
                    model_saw_ff = 1'b0;
                    model_count  = '0;
                    model_length = '0;
                end else begin
                    model_saw_ff = (b == HEAD_FIRST);
                end
            end
            PH_LEN: begin
                model_length = model_length | (32'(b) << (8 * model_count[1:0]));
                model_count  = model_count + 13'd1;
                if (model_count == 13'd4) begin
                    // A refused length ends the frame right here.
                    if (model_length < MIN_LENGTH || model_length > model_max_length ||
                        model_length > BUFFER_BYTES - FRAME_OVERHEAD) begin
                        model_phase  = PH_HUNT;
                        model_saw_ff = 1'b0;
                        model_count  = '0;
                        pending_results.push_back('{kind: KIND_END, payload_byte: '0,
                            command_code: '0, frame_status: ST_BAD_LEN,
                            payload_count: '0, last: 1'b1});
                    end else begin
                        model_phase   = PH_CMD;
                        model_count   = '0;
                        model_command = '0;
                    end
                end
            end
            PH_CMD: begin
                if (model_count == 13'd0) begin
                    model_command = {8'h00, b};
                    model_count   = 13'd1;
                end else begin
                    model_command[15:8] = b;
                    model_count = '0;
                    model_sum   = '0;
                    model_phase = (model_length == 32'(MIN_LENGTH)) ? PH_CHKL : PH_DATA;
                end
            end
            PH_DATA: begin
                model_sum   = model_sum + SUM_W'(b);
                model_count = model_count + 13'd1;
                if (32'(model_count) >= model_length - 32'd4)
                    model_phase = PH_CHKL;
                pending_results.push_back('{kind: KIND_PAYLOAD, payload_byte: b,
                    command_code: model_command, frame_status: ST_OK,
                    payload_count: '0, last: 1'b0});
            end
            PH_CHKL: begin
                model_check_low = b;
                model_phase     = PH_CHKH;
            end
            PH_CHKH: begin
                model_phase  = PH_HUNT;
                model_saw_ff = 1'b0;
                model_count  = '0;
                pending_results.push_back('{kind: KIND_END, payload_byte: '0,
                    command_code: model_command,
                    frame_status: ({b, model_check_low} == model_sum) ? ST_OK : ST_CHECKSUM,
                    payload_count: LEN_W'(model_length - 32'd4), last: 1'b1});
            end
            default: begin
                model_phase  = PH_HUNT;
                model_saw_ff = 1'b0;
                model_count  = '0;
            end
        endcase
    endfunction

    // Send one byte, opening a new burst after a random gap when needed.
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        predict_frame_byte(value);
        bytes_sent++;
    endtask

    // Hold the input until every expected result has been read out.
    task automatic wait_for_drain();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_length(input logic [LEN_W-1:0] value);
        wait_for_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        model_max_length = value;
        cfg_wr_en <= 1'b0;
    endtask

    // Send head and length; the body follows only if the length was taken.
    // A negative fill gives random payload bytes.
    task automatic send_frame(input logic [31:0] len_field, input logic [CMD_W-1:0] cmd,
                              input int fill, input bit corrupt);
        logic [SUM_W-1:0]  sum;
        logic [SUM_W-1:0]  check;
        logic [BYTE_W-1:0] b;
        sum = '0;
        send_byte(HEAD_FIRST);
        send_byte(HEAD_SECOND);
        for (int i = 0; i < 4; i++)
            send_byte(len_field[8*i +: 8]);
        if (model_phase != PH_CMD)
            return;
        send_byte(cmd[7:0]);
        send_byte(cmd[15:8]);
        for (int unsigned i = 0; i < len_field - 32'd4; i++) begin
            b = (fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill);
            sum = sum + SUM_W'(b);
            send_byte(b);
        end
        check = corrupt ? sum ^ SUM_W'($urandom_range(1, 65535)) : sum;
        send_byte(check[7:0]);
        send_byte(check[15:8]);
    endtask

    // Head hunting and the three report kinds with the reset limit.
    task automatic test_head_hunt_and_status();
        // Repeated FF before the head, then an empty payload.
        send_byte(HEAD_FIRST);
        send_frame(32'd4, 16'h1234, 0, 1'b0);
        send_frame(32'd3, 16'h0000, 0, 1'b0);
        send_frame(32'd5, 16'hFFFF, 8'hFF, 1'b0);
        send_frame(32'd6, 16'h0000, 8'h00, 1'b1);
        send_frame(32'hFFFF_FFFF, 16'h0000, 0, 1'b0);
        // A broken head is ignored.
        send_byte(HEAD_FIRST);
        send_byte(8'h00);
        send_frame(32'd7, 16'h8001, -1, 1'b0);
    endtask

    // Lengths right at and just past the limit at its low end and at a middle
    // value, and one past the reset limit, which also overflows the buffer.
    task automatic test_length_limits();
        write_max_length(MIN_LENGTH);
        send_frame(32'd4, 16'h5AA5, 0, 1'b0);
        send_frame(32'd5, 16'h5AA5, 0, 1'b0);
        write_max_length(LEN_W'(64));
        send_frame(32'd64, 16'hC3C3, -1, 1'b0);
        send_frame(32'd65, 16'hC3C3, -1, 1'b0);
        write_max_length(MAX_LENGTH_RST);
        send_frame(32'(MAX_LENGTH_RST) + 32'd1, 16'hC3C3, -1, 1'b0);
    endtask

    // Mostly well-formed frames, with refused lengths, bad sums and noise mixed in.
    task automatic test_random_traffic(input logic [LEN_W-1:0] limit, input int unsigned budget);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned n;
        logic [31:0] len;
        write_max_length(limit);
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame(32'd4 + $urandom_range(0, 24), CMD_W'($urandom), -1, 1'b0);
            end else if (pick < 78) begin
                send_frame(32'd4 + $urandom_range(0, 24), CMD_W'($urandom), -1, 1'b1);
            end else if (pick < 84) begin
                case ($urandom_range(0, 2))
                    0: len = $urandom_range(0, 3);
                    1: len = 32'(model_max_length) + 32'd1;
                    default: len = {8'($urandom_range(1, 255)), 24'($urandom)};
                endcase
                send_frame(len, CMD_W'($urandom), -1, 1'b0);
            end else if (pick < 88) begin
                send_frame(32'd4 + $urandom_range(25, 300), CMD_W'($urandom), -1,
                           1'($urandom_range(0, 1)));
            end else if (pick < 94) begin
                send_byte(HEAD_FIRST);
                send_byte(BYTE_W'($urandom_range(0, 253)));
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(BYTE_W'($urandom_range(0, 254)));
            end
        end
    endtask

    // Receiver pacing: free running, random, or sparse, each for a random stretch.
    always @(posedge aclk) begin
        if (rx_pace_left == 0) begin
            rx_pace      = rx_pace_t'($urandom_range(0, 2));
            rx_pace_left = $urandom_range(20, 200);
        end else begin
            rx_pace_left--;
        end
        case (rx_pace)
            RX_FREE:   m_tready <= 1'b1;
            RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
            default:   m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Compare every accepted result with the oldest expectation.
    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, got tdata %0h tuser %0b",
                             $time, m_tdata, m_tuser);
            end else begin
                want = pending_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_tuser));
                check_field("payload_byte", 32'(want.payload_byte),
                            32'(m_tdata[0 +: BYTE_W]));
                check_field("command_code", 32'(want.command_code),
                            32'(m_tdata[BYTE_W +: CMD_W]));
                check_field("frame_status", 32'(want.frame_status),
                            32'(m_tdata[BYTE_W + CMD_W +: STATUS_W]));
                check_field("payload_count", 32'(want.payload_count),
                            32'(m_tdata[BYTE_W + CMD_W + STATUS_W +: LEN_W]));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_head_hunt_and_status();
        test_length_limits();
        test_random_traffic(MAX_LENGTH_RST, 550);
        test_random_traffic(MIN_LENGTH, 250);
        test_random_traffic(LEN_W'($urandom_range(5, 60)), 450);
        test_random_traffic(LEN_W'(20), 350);
        wait_for_drain();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/lfpd_pkg.sv
hdl/length_framed_packet_deframer.sv
tb/tb_length_framed_packet_deframer.sv
